[design/dlp_pkg.sv]
// Package for the DHCP lease pool: sizes, codes, entry layout and the
// command/status structs between controller and datapath. No dependencies.
package dlp_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 5;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_PENDING  = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;
    localparam logic [1:0] ST_EXPIRED  = 2'd3;

    localparam logic [1:0] OP_DISCOVER = 2'd0;
    localparam logic [1:0] OP_REQUEST  = 2'd1;

    localparam logic [1:0] KIND_OFFER  = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_REFUSE = 2'd2;

    localparam logic [2:0] REG_POOL_SIZE     = 3'd0;
    localparam logic [2:0] REG_DEFAULT_LEASE = 3'd1;
    localparam logic [2:0] REG_MAX_LEASE     = 3'd2;
    localparam logic [2:0] REG_MIN_LEASE     = 3'd3;
    localparam logic [2:0] REG_SERVER_ID     = 3'd4;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] owner;
        logic [31:0] expiry;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0] pool_n;
        logic [31:0]      default_lease;
        logic [31:0]      max_lease;
        logic [31:0]      min_lease;
        logic [15:0]      server_id;
    } t_cfg;

    typedef struct packed {
        logic             clr;
        logic             rd;
        logic [IDX_W-1:0] idx;
        logic             proc;
        logic [IDX_W-1:0] pidx;
        logic             capture;
        logic             lease1;
        logic             lease2;
        logic             lease3;
        logic             fin;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

[design/dlp_cfg.sv]
// APB register file for the lease pool settings.
// Depends on dlp_pkg.
module dlp_cfg
    import dlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [10:0] r_pool_size;
    logic [31:0] r_default_lease;
    logic [31:0] r_max_lease;
    logic [31:0] r_min_lease;
    logic [15:0] r_server_id;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size     <= 11'd1024;
            r_default_lease <= 32'd3600;
            r_max_lease     <= 32'd7200;
            r_min_lease     <= 32'd60;
            r_server_id     <= 16'd1;
        end else if (wr) begin
            unique case (paddr[4:2])
                REG_POOL_SIZE:     r_pool_size     <= pwdata[10:0];
                REG_DEFAULT_LEASE: r_default_lease <= pwdata;
                REG_MAX_LEASE:     r_max_lease     <= pwdata;
                REG_MIN_LEASE:     r_min_lease     <= pwdata;
                REG_SERVER_ID:     r_server_id     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_POOL_SIZE:     prdata = {21'd0, r_pool_size};
            REG_DEFAULT_LEASE: prdata = r_default_lease;
            REG_MAX_LEASE:     prdata = r_max_lease;
            REG_MIN_LEASE:     prdata = r_min_lease;
            REG_SERVER_ID:     prdata = {16'd0, r_server_id};
            default:           prdata = 32'd0;
        endcase
    end

    // effective size clamped to 1..POOL_DEPTH
    always_comb begin
        if (r_pool_size == 11'd0)
            o_cfg.pool_n = CNT_W'(1);
        else if ({{CNT_W{1'b0}}, r_pool_size} > (CNT_W + 11)'(POOL_DEPTH))
            o_cfg.pool_n = CNT_W'(POOL_DEPTH);
        else
            o_cfg.pool_n = CNT_W'(r_pool_size);
        o_cfg.default_lease = r_default_lease;
        o_cfg.max_lease     = r_max_lease;
        o_cfg.min_lease     = r_min_lease;
        o_cfg.server_id     = r_server_id;
    end

endmodule

[design/dlp_ctrl.sv]
// Sequencer: clearing pass, per-request pool scan, lease steps and finish.
// Depends on dlp_pkg.
module dlp_ctrl
    import dlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_s_tvalid,
    input  t_sts i_sts,
    output logic o_s_tready,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_L1   = 3'd3;
    localparam logic [2:0] S_L2   = 3'd4;
    localparam logic [2:0] S_L3   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.idx  = r_cnt[IDX_W-1:0];
        o_cmd.proc = r_pv;
        o_cmd.pidx = r_pidx;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                n_cnt     = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(POOL_DEPTH - 1))
                    n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
                n_cnt         = '0;
                if (i_s_tvalid)
                    n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.rd = r_cnt < i_cfg.pool_n;
                if (o_cmd.rd)
                    n_cnt = r_cnt + CNT_W'(1);
                else if (!r_pv)
                    n_state = S_L1;
            end
            S_L1: begin
                o_cmd.lease1 = 1'b1;
                n_state      = S_L2;
            end
            S_L2: begin
                o_cmd.lease2 = 1'b1;
                n_state      = S_L3;
            end
            S_L3: begin
                o_cmd.lease3 = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pv    <= o_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt[IDX_W-1:0];
    end

endmodule

[design/dlp_data.sv]
// Datapath: lease table memory, aging and search during the scan, lease
// arithmetic and the reply register. Depends on dlp_pkg.
module dlp_data
    import dlp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    input  logic [111:0] i_s_tdata,
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,
    output logic [1:0]   o_m_tuser
);

    t_entry mem [POOL_DEPTH];
    t_entry r_rdata;

    logic [31:0] r_now, r_req;
    logic [15:0] r_client, r_target, r_addr;
    logic        r_bcast;
    logic [1:0]  r_op;

    logic             r_own_v, r_free_v, r_exp_v, r_hit;
    logic [IDX_W-1:0] r_own_i, r_free_i, r_exp_i;
    logic [32:0]      r_len;
    logic             r_use_dflt;
    logic [31:0]      r_exp;

    logic             r_m_tvalid;
    logic [63:0]      r_m_tdata;
    logic [1:0]       r_m_tuser;

    t_entry           aged, upd, w_data;
    logic             w_en;
    logic [IDX_W-1:0] w_idx, sel_i;
    logic             rel_mode, valid_cl, disc_ok, req_ok, ack;
    logic [32:0]      diff, sum;

    // aging and release of the entry read last cycle
    always_comb begin
        aged = r_rdata;
        if (r_rdata.expiry != 32'd0 && r_rdata.expiry <= r_now) begin
            if (r_rdata.status == ST_PENDING)
                aged = '0;
            else if (r_rdata.status == ST_OCCUPIED) begin
                aged.status = ST_EXPIRED;
                aged.expiry = 32'd0;
            end
        end
        upd = aged;
        if (rel_mode && aged.status == ST_PENDING && aged.owner == r_client)
            upd = '0;
    end

    assign valid_cl = r_client != 16'd0;
    assign rel_mode = valid_cl && r_op == OP_REQUEST && !r_bcast
                      && r_target != i_cfg.server_id;
    assign disc_ok  = valid_cl && r_op == OP_DISCOVER && r_bcast
                      && (r_own_v || r_free_v || r_exp_v);
    assign req_ok   = valid_cl && r_op == OP_REQUEST && !r_bcast
                      && r_target == i_cfg.server_id;
    assign ack      = req_ok && r_hit;
    assign sel_i    = r_own_v ? r_own_i : (r_free_v ? r_free_i : r_exp_i);

    always_comb begin
        w_en   = 1'b0;
        w_idx  = i_cmd.idx;
        w_data = '0;
        if (i_cmd.clr) begin
            w_en = 1'b1;
        end else if (i_cmd.proc) begin
            w_en   = 1'b1;
            w_idx  = i_cmd.pidx;
            w_data = upd;
        end else if (i_cmd.fin && (disc_ok || ack)) begin
            w_en          = 1'b1;
            w_idx         = disc_ok ? sel_i : (r_addr[IDX_W-1:0] - IDX_W'(1));
            w_data.status = disc_ok ? ST_PENDING : ST_OCCUPIED;
            w_data.owner  = r_client;
            w_data.expiry = r_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en)
            mem[w_idx] <= w_data;
        if (i_cmd.rd)
            r_rdata <= mem[i_cmd.idx];
    end

    // request capture and search results
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now    <= i_s_tdata[31:0];
            r_client <= i_s_tdata[47:32];
            r_target <= i_s_tdata[63:48];
            r_addr   <= i_s_tdata[79:64];
            r_req    <= i_s_tdata[111:80];
            r_bcast  <= i_s_tuser[0];
            r_op     <= i_s_tuser[2:1];
            r_own_v  <= 1'b0;
            r_free_v <= 1'b0;
            r_exp_v  <= 1'b0;
            r_hit    <= 1'b0;
        end else if (i_cmd.proc) begin
            if (!r_own_v && aged.owner == r_client) begin
                r_own_v <= 1'b1;
                r_own_i <= i_cmd.pidx;
            end
            if (!r_free_v && aged.status == ST_FREE) begin
                r_free_v <= 1'b1;
                r_free_i <= i_cmd.pidx;
            end
            if (!r_exp_v && aged.status == ST_EXPIRED) begin
                r_exp_v <= 1'b1;
                r_exp_i <= i_cmd.pidx;
            end
            if (r_addr == (16'(i_cmd.pidx) + 16'd1) && aged.owner == r_client)
                r_hit <= 1'b1;
        end
    end

    // lease length: default, or clamp to max then min; then saturating add
    assign diff = {1'b0, r_req} - {1'b0, r_now};
    assign sum  = {1'b0, r_now} + {1'b0, r_len[31:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.lease1) begin
            r_use_dflt <= r_req == 32'd0;
            if (r_req == 32'd0)
                r_len <= {1'b0, i_cfg.default_lease};
            else if ($signed(diff) > $signed({1'b0, i_cfg.max_lease}))
                r_len <= {1'b0, i_cfg.max_lease};
            else
                r_len <= diff;
        end
        if (i_cmd.lease2 && !r_use_dflt
                && $signed(r_len) < $signed({1'b0, i_cfg.min_lease}))
            r_len <= {1'b0, i_cfg.min_lease};
        if (i_cmd.lease3)
            r_exp <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end

    // reply register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_m_tvalid <= 1'b0;
        else if (i_cmd.fin && (disc_ok || req_ok))
            r_m_tvalid <= 1'b1;
        else if (i_m_tready)
            r_m_tvalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin && (disc_ok || req_ok)) begin
            r_m_tuser        <= disc_ok ? KIND_OFFER : (ack ? KIND_ACK : KIND_REFUSE);
            r_m_tdata[15:0]  <= r_client;
            r_m_tdata[31:16] <= disc_ok ? (16'(sel_i) + 16'd1) : r_addr;
            r_m_tdata[63:32] <= (disc_ok || ack) ? r_exp : 32'd0;
        end
    end

    assign o_sts.out_free = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid     = r_m_tvalid;
    assign o_m_tdata      = r_m_tdata;
    assign o_m_tuser      = r_m_tuser;

endmodule

[design/dhcp_lease_pool.sv]
// DHCP lease pool top level: APB settings, sequencer and datapath.
// Depends on dlp_pkg, dlp_cfg, dlp_ctrl, dlp_data.
//
// Usage: one request enters on the s_ stream (tdata: now, client_id,
// target_id, req_addr, req_expiry; tuser: broadcast, operation). It ages
// and searches the whole pool, then gives at most one reply on the m_
// stream (tdata: reply_client, reply_addr, reply_expiry; tuser: reply_kind).
// Settings go through the APB port; the user writes them only while the
// block is idle, which the block itself does not enforce. Reset: a clearing
// pass writes all 1024 table entries with s_tready low; APB writes are taken
// meanwhile. Requests are handled one at a time, each by a sequential scan
// through the single-port-read table, one entry a cycle.
// Stall: the reply register holds while m_tready is low; the next request
// is accepted and scanned meanwhile, and waits at its finish step until
// the reply register is free.
module dhcp_lease_pool
    import dlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [111:0]      s_tdata,  // now, client_id, target_id, req_addr, req_expiry
    input  logic [2:0]        s_tuser,  // broadcast, operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,  // reply_client, reply_addr, reply_expiry
    output logic [1:0]        m_tuser,  // reply_kind
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    dlp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (s_tvalid),
        .i_sts      (sts),
        .o_s_tready (s_tready),
        .o_cmd      (cmd)
    );

    dlp_data u_data (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken during a scan");

    a_wr_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr, cmd.proc, cmd.fin}))
        else $error("table write port conflict");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && !s_tready)
        else $error("activity straight after reset");

endmodule

[tb/dhcp_lease_checker.sv]
`timescale 1ns / 1ps
// Lease checker for dhcp_lease_pool: follows APB writes and both streams,
// predicts each reply from its own copy of the lease table. Depends on dlp_pkg.
module dhcp_lease_checker
    import dlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [111:0]      s_tdata,
    input  logic [2:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [63:0]       m_tdata,
    input  logic [1:0]        m_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] client;
        logic [15:0] addr;
        logic [31:0] expiry;
    } t_reply;

    t_reply      replies_due[$];
    logic [1:0]  lease_state[POOL_DEPTH];
    logic [15:0] lease_owner[POOL_DEPTH];
    logic [31:0] lease_end_at[POOL_DEPTH];
    logic [10:0] cfg_pool;
    logic [31:0] cfg_default;
    logic [31:0] cfg_max;
    logic [31:0] cfg_min;
    logic [15:0] cfg_server;

    assign o_pending = replies_due.size();

    function automatic int pool_span();
        int n;
        n = cfg_pool;
        if (n < 1) n = 1;
        if (n > POOL_DEPTH) n = POOL_DEPTH;
        return n;
    endfunction

    function automatic logic [31:0] lease_end(logic [31:0] now, logic [31:0] asked);
        longint len;
        longint stop;
        if (asked == 0) begin
            len = longint'(cfg_default);
        end else begin
            len = longint'(asked) - longint'(now);
            if (len > longint'(cfg_max)) len = longint'(cfg_max);
            if (len < longint'(cfg_min)) len = longint'(cfg_min);
        end
        stop = longint'(now) + len;
        if (stop > 64'sd4294967295) stop = 64'sd4294967295;
        return stop[31:0];
    endfunction

    // ages the table, applies one request, queues its reply if any
    task automatic serve_request(logic [111:0] d, logic [2:0] u);
        logic [31:0] now;
        logic [15:0] client, target, addr;
        logic [31:0] asked;
        logic        bcast;
        logic [1:0]  op;
        int          n, k, hit;
        t_reply      r;
        now    = d[31:0];
        client = d[47:32];
        target = d[63:48];
        addr   = d[79:64];
        asked  = d[111:80];
        bcast  = u[0];
        op     = u[2:1];
        n      = pool_span();
        for (k = 0; k < n; k++) begin
            if (lease_end_at[k] != 0 && lease_end_at[k] <= now) begin
                if (lease_state[k] == ST_PENDING) begin
                    lease_state[k]  = ST_FREE;
                    lease_owner[k]  = 0;
                    lease_end_at[k] = 0;
                end else if (lease_state[k] == ST_OCCUPIED) begin
                    lease_state[k]  = ST_EXPIRED;
                    lease_end_at[k] = 0;
                end
            end
        end
        if (client == 0) return;
        if (op == OP_DISCOVER) begin
            if (!bcast) return;
            hit = -1;
            for (k = 0; k < n && hit < 0; k++) if (lease_owner[k] == client) hit = k;
            for (k = 0; k < n && hit < 0; k++) if (lease_state[k] == ST_FREE) hit = k;
            for (k = 0; k < n && hit < 0; k++) if (lease_state[k] == ST_EXPIRED) hit = k;
            if (hit < 0) return;
            lease_state[hit]  = ST_PENDING;
            lease_owner[hit]  = client;
            lease_end_at[hit] = lease_end(now, asked);
            r.kind   = KIND_OFFER;
            r.client = client;
            r.addr   = 16'(hit + 1);
            r.expiry = lease_end_at[hit];
            replies_due.push_back(r);
            return;
        end
        if (op != OP_REQUEST || bcast) return;
        if (target != cfg_server) begin
            for (k = 0; k < n; k++) begin
                if (lease_state[k] == ST_PENDING && lease_owner[k] == client) begin
                    lease_state[k]  = ST_FREE;
                    lease_owner[k]  = 0;
                    lease_end_at[k] = 0;
                end
            end
            return;
        end
        r.client = client;
        r.addr   = addr;
        if (addr == 0 || addr > n || lease_owner[addr-1] != client) begin
            r.kind   = KIND_REFUSE;
            r.expiry = 0;
        end else begin
            lease_state[addr-1]  = ST_OCCUPIED;
            lease_end_at[addr-1] = lease_end(now, asked);
            r.kind   = KIND_ACK;
            r.expiry = lease_end_at[addr-1];
        end
        replies_due.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_reply r;
        if (!i_rst_n) begin
            for (int k = 0; k < POOL_DEPTH; k++) begin
                lease_state[k]  = ST_FREE;
                lease_owner[k]  = 0;
                lease_end_at[k] = 0;
            end
            cfg_pool     = 11'd1024;
            cfg_default  = 32'd3600;
            cfg_max      = 32'd7200;
            cfg_min      = 32'd60;
            cfg_server   = 16'd1;
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_POOL_SIZE:     cfg_pool    = pwdata[10:0];
                    REG_DEFAULT_LEASE: cfg_default = pwdata;
                    REG_MAX_LEASE:     cfg_max     = pwdata;
                    REG_MIN_LEASE:     cfg_min     = pwdata;
                    REG_SERVER_ID:     cfg_server  = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) serve_request(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected reply kind=%0d client=%0h", m_tuser, m_tdata[15:0]);
                    o_fail_count++;
                end else begin
                    r = replies_due.pop_front();
                    if (m_tuser !== r.kind) begin
                        $error("reply_kind exp %0d got %0d", r.kind, m_tuser);
                        o_fail_count++;
                    end
                    if (m_tdata[15:0] !== r.client) begin
                        $error("reply_client exp %0h got %0h", r.client, m_tdata[15:0]);
                        o_fail_count++;
                    end
                    if (m_tdata[31:16] !== r.addr) begin
                        $error("reply_addr exp %0h got %0h", r.addr, m_tdata[31:16]);
                        o_fail_count++;
                    end
                    if (m_tdata[63:32] !== r.expiry) begin
                        $error("reply_expiry exp %0h got %0h", r.expiry, m_tdata[63:32]);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

[tb/tb_dhcp_lease_pool.sv]
`timescale 1ns / 1ps
// Testbench top for dhcp_lease_pool: clock, reset, APB settings and request
// stimulus with random stalls. Depends on dlp_pkg, the DUT, dhcp_lease_checker.
module tb_dhcp_lease_pool;
    import dlp_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] OP_OTHER = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid, s_tready;
    logic [111:0]      s_tdata;   // now, client_id, target_id, req_addr, req_expiry
    logic [2:0]        s_tuser;   // broadcast, operation
    logic              m_tvalid, m_tready;
    logic [63:0]       m_tdata;   // reply_client, reply_addr, reply_expiry
    logic [1:0]        m_tuser;   // reply_kind
    logic              psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata, prdata;
    int                fail_count, replies_open;
    int                cycles;
    bit                quiet;
    int                stall_left;
    logic [31:0]       clock_now;
    int                span;
    logic [15:0]       my_server;

    dhcp_lease_pool DUT (.*);

    dhcp_lease_checker u_checker (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(replies_open)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // reply-side back-pressure
    always @(posedge i_clk) begin
        if (!quiet && stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [10:0] pool, logic [31:0] dflt, logic [31:0] mx,
                             logic [31:0] mn, logic [15:0] srv);
        reg_write(REG_POOL_SIZE, {21'd0, pool});
        reg_write(REG_DEFAULT_LEASE, dflt);
        reg_write(REG_MAX_LEASE, mx);
        reg_write(REG_MIN_LEASE, mn);
        reg_write(REG_SERVER_ID, {16'd0, srv});
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        span      = (pool == 0) ? 1 : (pool > POOL_DEPTH) ? POOL_DEPTH : pool;
        my_server = srv;
    endtask

    task automatic send_request(logic [31:0] now, logic [15:0] client, logic [15:0] target,
                                logic bcast, logic [1:0] op, logic [15:0] addr,
                                logic [31:0] asked);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {asked, addr, target, client, now};
        s_tuser  <= {op, bcast};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (replies_open != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    task automatic random_request();
        logic [15:0] client, target, addr;
        logic [31:0] asked;
        logic        bcast;
        logic [1:0]  op;
        int          pick;
        longint      t;
        pick = $urandom_range(0, 99);
        t = longint'(clock_now) + ((pick < 85) ? $urandom_range(0, 40) :
                                   (pick < 95) ? $urandom_range(100, 400) : 0);
        clock_now = (t > 64'sd4294967295) ? 32'hFFFF_FFFF : t[31:0];
        pick = $urandom_range(0, 99);
        if (pick < 3) client = 0;
        else if (pick < 8) client = 16'($urandom);
        else client = 16'($urandom_range(1, (span > 40) ? 40 : span + 2));
        target = ($urandom_range(0, 3) == 0) ? 16'($urandom) : my_server;
        addr   = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, span + 1));
        pick = $urandom_range(0, 9);
        asked = (pick < 4) ? 32'd0 : (pick < 8) ? clock_now + $urandom_range(0, 400) : $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            op = OP_DISCOVER; bcast = 1'b1;
        end else if (pick < 88) begin
            op = OP_REQUEST; bcast = 1'b0;
        end else if (pick < 92) begin
            op = OP_DISCOVER; bcast = 1'b0;
        end else if (pick < 95) begin
            op = OP_REQUEST; bcast = 1'b1;
        end else begin
            op = $urandom_range(0, 1) ? OP_OTHER : OP_RSVD; bcast = 1'($urandom);
        end
        send_request(clock_now, client, target, bcast, op, addr, asked);
    endtask

    task automatic random_phase(int count);
        repeat (count) random_request();
        drain();
    endtask

    initial begin
        quiet = 0; clock_now = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero lease at time zero gives an entry that never ages
        configure(11'd2, 32'd0, 32'd200, 32'd10, 16'd5);
        send_request(0, 16'd9, 16'd0, 1'b1, OP_DISCOVER, 16'd0, 32'd0);
        drain();
        configure(11'd0, 32'd100, 32'd200, 32'd10, 16'd5);
        send_request(10, 16'd9, 16'd0, 1'b1, OP_DISCOVER, 16'd0, 32'd0);
        send_request(12, 16'd9, 16'd5, 1'b0, OP_REQUEST, 16'd1, 32'd0);
        drain();
        configure(11'd2, 32'd100, 32'd200, 32'd10, 16'd5);
        send_request(20, 16'd1, 16'd0, 1'b1, OP_DISCOVER, 16'd0, 32'd0);
        send_request(21, 16'd1, 16'd0, 1'b1, OP_DISCOVER, 16'd0, 32'd50);
        send_request(22, 16'd1, 16'd5, 1'b0, OP_REQUEST, 16'd1, 32'd5000);
        send_request(23, 16'd2, 16'd0, 1'b1, OP_DISCOVER, 16'd0, 32'd0);
        send_request(24, 16'd3, 16'd0, 1'b1, OP_DISCOVER, 16'd0, 32'd0);
        send_request(25, 16'd2, 16'd7, 1'b0, OP_REQUEST, 16'd2, 32'd0);
        send_request(26, 16'd3, 16'd5, 1'b0, OP_REQUEST, 16'd0, 32'd0);
        send_request(27, 16'd3, 16'd5, 1'b0, OP_REQUEST, 16'd3, 32'd0);
        send_request(28, 16'd3, 16'd5, 1'b0, OP_REQUEST, 16'd1, 32'd0);
        send_request(29, 16'd1, 16'd5, 1'b0, OP_REQUEST, 16'd1, 32'd3);
        send_request(30, 16'd4, 16'd5, 1'b0, OP_DISCOVER, 16'd0, 32'd0);
        send_request(31, 16'd4, 16'd5, 1'b1, OP_REQUEST, 16'd1, 32'd0);
        send_request(32, 16'd4, 16'd5, 1'b1, OP_OTHER, 16'd1, 32'd0);
        send_request(33, 16'd4, 16'd5, 1'b0, OP_RSVD, 16'd1, 32'd0);
        send_request(34, 16'd0, 16'd5, 1'b1, OP_DISCOVER, 16'd0, 32'd0);
        send_request(35, 16'hFFFF, 16'hFFFF, 1'b1, OP_DISCOVER, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(500, 16'd4, 16'd0, 1'b1, OP_DISCOVER, 16'd0, 32'd0);
        send_request(501, 16'd5, 16'd0, 1'b1, OP_DISCOVER, 16'd0, 32'd0);
        send_request(502, 16'd6, 16'hFFFF, 1'b0, OP_REQUEST, 16'hFFFF, 32'd0);
        send_request(503, 16'd5, 16'd5, 1'b0, OP_REQUEST, 16'd1, 32'd0);
        drain();
        clock_now = 600;

        configure(11'd4, 32'd50, 32'd300, 32'd20, 16'd5);
        random_phase(60);
        configure(11'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
        random_phase(40);
        configure(11'd2047, 32'd1000, 32'hFFFF_FFFF, 32'd0, 16'd1);
        random_phase(35);
        configure(11'd7, 32'd30, 32'd100, 32'd5, 16'h1234);
        random_phase(70);
        quiet = 1;
        clock_now = 32'hFFFF_F000;
        configure(11'd3, 32'd500, 32'd4000, 32'd100, 16'h8000);
        random_phase(60);

        if (fail_count == 0 && replies_open == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
design/dlp_pkg.sv
design/dlp_cfg.sv
design/dlp_ctrl.sv
design/dlp_data.sv
design/dhcp_lease_pool.sv
tb/dhcp_lease_checker.sv
tb/tb_dhcp_lease_pool.sv
